>>> rtl/core/kss_pkg.sv
package kss_pkg;

   // Default sizing of the store
   localparam int SLOTS_DEFAULT     = 8;
   localparam int MAX_BYTES_DEFAULT = 256;
   localparam int QUEUE_DEPTH       = 2;

   // Request kind codes as they arrive on the input
   localparam logic [2:0] KIND_SET    = 3'd0;
   localparam logic [2:0] KIND_DATA   = 3'd1;
   localparam logic [2:0] KIND_GET    = 3'd2;
   localparam logic [2:0] KIND_INFO   = 3'd3;
   localparam logic [2:0] KIND_REMOVE = 3'd4;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NOSPACE = 2'd1,
      STATUS_ABSENT  = 2'd2,
      STATUS_INVALID = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_SET,
      OP_DATA,
      OP_GET,
      OP_INFO,
      OP_REMOVE,
      OP_BAD
   } op_type;

   // Classified request handed from front to back
   typedef struct packed {
      op_type      op;
      logic [63:0] uid;
      logic [8:0]  length;
      logic [8:0]  offset;
      logic [4:0]  word_index;
      logic [63:0] data_in;
      logic        too_long;
      logic        bad_index;
   } cmd_type;

   // One result item
   typedef struct packed {
      status_type  status;
      logic [63:0] data_out;
      logic [3:0]  byte_count;
      logic [8:0]  copied_length;
      logic [8:0]  stored_size;
      logic        last;
   } rsp_type;

endpackage

>>> rtl/core/kss_queue.sv
module kss_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = kss_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the transfer payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/kss_front.sv
module kss_front #(
   parameter int MAX_BYTES = kss_pkg::MAX_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [2:0]       req_kind,
   input  logic [63:0]      req_uid,
   input  logic [8:0]       req_length,
   input  logic [8:0]       req_offset,
   input  logic [4:0]       req_word_index,
   input  logic [63:0]      req_data_in,
   output logic             cmd_valid,
   input  logic             cmd_pop,
   output kss_pkg::cmd_type cmd
);

   localparam int WPS   = (MAX_BYTES + 7) / 8;
   localparam int CMD_W = $bits(kss_pkg::cmd_type);

   kss_pkg::cmd_type cmd_new;
   logic [CMD_W-1:0] q_out;
   logic             q_empty;

   // Classify the request and flag argument faults early
   always_comb begin
      cmd_new            = '0;
      cmd_new.uid        = req_uid;
      cmd_new.length     = req_length;
      cmd_new.offset     = req_offset;
      cmd_new.word_index = req_word_index;
      cmd_new.data_in    = req_data_in;
      cmd_new.too_long   = (req_length > 9'(MAX_BYTES));
      cmd_new.bad_index  = ({1'b0, req_word_index} >= 6'(WPS));
      case (req_kind)
         kss_pkg::KIND_SET:    cmd_new.op = kss_pkg::OP_SET;
         kss_pkg::KIND_DATA:   cmd_new.op = kss_pkg::OP_DATA;
         kss_pkg::KIND_GET:    cmd_new.op = kss_pkg::OP_GET;
         kss_pkg::KIND_INFO:   cmd_new.op = kss_pkg::OP_INFO;
         kss_pkg::KIND_REMOVE: cmd_new.op = kss_pkg::OP_REMOVE;
         default:              cmd_new.op = kss_pkg::OP_BAD;
      endcase
   end

   // Hold classified requests until the back end takes them
   kss_queue #(
      .WIDTH (CMD_W),
      .DEPTH (kss_pkg::QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cmd_new),
      .full      (full),
      .pop       (cmd_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   assign cmd_valid = !q_empty;
   assign cmd       = kss_pkg::cmd_type'(q_out);

endmodule

>>> rtl/core/kss_back.sv
module kss_back #(
   parameter int SLOTS     = kss_pkg::SLOTS_DEFAULT,
   parameter int MAX_BYTES = kss_pkg::MAX_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  kss_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output kss_pkg::rsp_type rsp_pkt
);

   localparam int WPS       = (MAX_BYTES + 7) / 8;
   localparam int WW        = (WPS > 1) ? $clog2(WPS) : 1;
   localparam int SW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int AW        = SW + WW;
   localparam int MEM_DEPTH = 1 << AW;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_RESOLVE,
      S_EXEC,
      S_GET_A,
      S_GET_B,
      S_GET_C
   } state_type;

   state_type        state_ff, state_in;
   kss_pkg::cmd_type cmd_ff, cmd_in;

   // Slot table
   logic [SLOTS-1:0] used_ff, used_in;
   logic [63:0]      key_ff [SLOTS];
   logic [63:0]      key_in [SLOTS];
   logic [8:0]       len_ff [SLOTS];
   logic [8:0]       len_in [SLOTS];
   logic [SW-1:0]    target_slot_ff, target_slot_in;
   logic             target_valid_ff, target_valid_in;

   // Lookup results
   logic [SLOTS-1:0] hit_vec_ff, hit_vec_in;
   logic [SLOTS-1:0] free_vec_ff, free_vec_in;
   logic             hit_ff, hit_in;
   logic             free_ok_ff, free_ok_in;
   logic [SW-1:0]    hit_slot_ff, hit_slot_in;
   logic [SW-1:0]    free_slot_ff, free_slot_in;
   logic             hit_any, free_any;
   logic [SW-1:0]    hit_idx, free_idx;

   // Read streaming
   logic [8:0]       rem_ff, rem_in;
   logic [8:0]       copy_ff, copy_in;
   logic [WW-1:0]    w_ff, w_in;
   logic [2:0]       shift_ff, shift_in;
   logic [63:0]      lo_ff, lo_in;
   logic [63:0]      rd_data_ff;

   // Data memory
   logic [63:0]      data_mem [MEM_DEPTH];
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [AW-1:0]    rd_addr;
   logic [WW-1:0]    rd_word;

   // Helpers for the execute step
   logic [8:0]       cur_len;
   logic [8:0]       avail;
   logic [8:0]       copy_len;
   logic [5:0]       off_word;
   logic [SW-1:0]    set_slot;
   logic [3:0]       n_bytes;
   logic [127:0]     pair_shifted;
   logic [63:0]      out_word;

   // Pick the lowest matching and lowest free slot
   always_comb begin
      hit_any  = 1'b0;
      hit_idx  = '0;
      free_any = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (hit_vec_ff[i]) begin
            hit_any = 1'b1;
            hit_idx = SW'(i);
         end
         if (free_vec_ff[i]) begin
            free_any = 1'b1;
            free_idx = SW'(i);
         end
      end
   end

   assign cur_len  = len_ff[hit_slot_ff];
   assign avail    = cur_len - cmd_ff.offset;
   assign copy_len = (cmd_ff.length < avail) ? cmd_ff.length : avail;
   assign off_word = cmd_ff.offset[8:3];
   assign set_slot = hit_ff ? hit_slot_ff : free_slot_ff;

   // Align the two fetched words and trim to the bytes still owed
   assign n_bytes      = (rem_ff > 9'd8) ? 4'd8 : rem_ff[3:0];
   assign pair_shifted = {rd_data_ff, lo_ff} >> {shift_ff, 3'b000};
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         out_word[b*8 +: 8] = (4'(b) < n_bytes) ? pair_shifted[b*8 +: 8] : 8'h00;
      end
   end

   assign rd_word   = (state_ff == S_GET_A) ? w_ff : w_ff + 1'b1;
   assign rd_addr   = {hit_slot_ff, rd_word};
   assign mem_waddr = {target_slot_ff, cmd_ff.word_index[WW-1:0]};

   // Sequence one request through lookup, resolve, execute and, for a get, the word stream
   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      used_in         = used_ff;
      key_in          = key_ff;
      len_in          = len_ff;
      target_slot_in  = target_slot_ff;
      target_valid_in = target_valid_ff;
      hit_vec_in      = hit_vec_ff;
      free_vec_in     = free_vec_ff;
      hit_in          = hit_ff;
      free_ok_in      = free_ok_ff;
      hit_slot_in     = hit_slot_ff;
      free_slot_in    = free_slot_ff;
      rem_in          = rem_ff;
      copy_in         = copy_ff;
      w_in            = w_ff;
      shift_in        = shift_ff;
      lo_in           = lo_ff;
      cmd_pop         = 1'b0;
      rsp_push        = 1'b0;
      mem_we          = 1'b0;
      rsp_pkt         = '0;
      rsp_pkt.status  = kss_pkg::STATUS_OK;
      rsp_pkt.last    = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            for (int i = 0; i < SLOTS; i++) begin
               hit_vec_in[i]  = used_ff[i] && (key_ff[i] == cmd_ff.uid);
               free_vec_in[i] = !used_ff[i];
            end
            state_in = S_RESOLVE;
         end
         S_RESOLVE: begin
            hit_in       = hit_any;
            hit_slot_in  = hit_idx;
            free_ok_in   = free_any;
            free_slot_in = free_idx;
            state_in     = S_EXEC;
         end
         S_EXEC: begin
            case (cmd_ff.op)
               kss_pkg::OP_SET: begin
                  rsp_push = !rsp_full;
                  if (cmd_ff.too_long || !(hit_ff || free_ok_ff)) begin
                     rsp_pkt.status = kss_pkg::STATUS_NOSPACE;
                  end else if (!rsp_full) begin
                     used_in[set_slot] = 1'b1;
                     key_in[set_slot]  = cmd_ff.uid;
                     len_in[set_slot]  = cmd_ff.length;
                     target_slot_in    = set_slot;
                     target_valid_in   = 1'b1;
                  end
               end
               kss_pkg::OP_DATA: begin
                  rsp_push = !rsp_full;
                  if (!target_valid_ff || cmd_ff.bad_index) begin
                     rsp_pkt.status = kss_pkg::STATUS_INVALID;
                  end else begin
                     mem_we = !rsp_full;
                  end
               end
               kss_pkg::OP_GET: begin
                  if (!hit_ff) begin
                     rsp_push       = !rsp_full;
                     rsp_pkt.status = kss_pkg::STATUS_ABSENT;
                  end else if (cmd_ff.offset > cur_len) begin
                     rsp_push       = !rsp_full;
                     rsp_pkt.status = kss_pkg::STATUS_INVALID;
                  end else if (copy_len == '0) begin
                     rsp_push = !rsp_full;
                  end else begin
                     rem_in   = copy_len;
                     copy_in  = copy_len;
                     w_in     = off_word[WW-1:0];
                     shift_in = cmd_ff.offset[2:0];
                     state_in = S_GET_A;
                  end
               end
               kss_pkg::OP_INFO: begin
                  rsp_push = !rsp_full;
                  if (!hit_ff) begin
                     rsp_pkt.status = kss_pkg::STATUS_ABSENT;
                  end else begin
                     rsp_pkt.stored_size = cur_len;
                  end
               end
               kss_pkg::OP_REMOVE: begin
                  rsp_push = !rsp_full;
                  if (!hit_ff) begin
                     rsp_pkt.status = kss_pkg::STATUS_ABSENT;
                  end else if (!rsp_full) begin
                     used_in[hit_slot_ff] = 1'b0;
                     key_in[hit_slot_ff]  = '0;
                     len_in[hit_slot_ff]  = '0;
                     if (target_valid_ff && (target_slot_ff == hit_slot_ff)) begin
                        target_valid_in = 1'b0;
                     end
                  end
               end
               default: begin
                  rsp_push       = !rsp_full;
                  rsp_pkt.status = kss_pkg::STATUS_INVALID;
               end
            endcase
            if (rsp_push) begin
               state_in = S_IDLE;
            end
         end
         S_GET_A: begin
            state_in = S_GET_B;
         end
         S_GET_B: begin
            lo_in    = rd_data_ff;
            state_in = S_GET_C;
         end
         S_GET_C: begin
            rsp_pkt.data_out      = out_word;
            rsp_pkt.byte_count    = n_bytes;
            rsp_pkt.copied_length = copy_ff;
            rsp_pkt.last          = (rem_ff <= 9'd8);
            if (!rsp_full) begin
               rsp_push = 1'b1;
               rem_in   = rem_ff - {5'b0, n_bytes};
               if (rem_ff <= 9'd8) begin
                  state_in = S_IDLE;
               end else begin
                  w_in     = w_ff + 1'b1;
                  state_in = S_GET_B;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold control state and the slot table
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         used_ff         <= '0;
         target_slot_ff  <= '0;
         target_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            key_ff[i] <= '0;
            len_ff[i] <= '0;
         end
      end else begin
         state_ff        <= state_in;
         used_ff         <= used_in;
         target_slot_ff  <= target_slot_in;
         target_valid_ff <= target_valid_in;
         key_ff          <= key_in;
         len_ff          <= len_in;
      end
   end

   // Hold the working payload of the current request
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      hit_vec_ff   <= hit_vec_in;
      free_vec_ff  <= free_vec_in;
      hit_ff       <= hit_in;
      free_ok_ff   <= free_ok_in;
      hit_slot_ff  <= hit_slot_in;
      free_slot_ff <= free_slot_in;
      rem_ff       <= rem_in;
      copy_ff      <= copy_in;
      w_ff         <= w_in;
      shift_ff     <= shift_in;
      lo_ff        <= lo_in;
   end

   // Data words: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         data_mem[mem_waddr] <= cmd_ff.data_in;
      end
      rd_data_ff <= data_mem[rd_addr];
   end

   ap_push_has_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result transfer issued while the result queue is full");

   ap_target_is_used: assert property (@(posedge clock) disable iff (reset)
      target_valid_ff |-> used_ff[target_slot_ff])
      else $error("write target points at a free slot");

   ap_write_needs_target: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> target_valid_ff)
      else $error("data word written without a valid target");

   ap_stream_owes_bytes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GET_C) |-> (rem_ff != '0))
      else $error("read stream active with nothing left to copy");

   ap_last_word_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GET_C && rsp_push && rsp_pkt.last) |=> (state_ff == S_IDLE))
      else $error("read stream continued past its last word");

endmodule

>>> rtl/core/keyed_slot_store_top.sv
// Each request passes the back end through queue pop, key compare, slot select and
// execute; a get with data then streams its words one at a time, paced by the
// registered read port of the data memory. The back end takes no new request until
// the current one is done, and it waits while the result queue is full.
// Reset clears the slot table, the write target and both queues; the data memory is
// not cleared and holds unknown words until written.
module keyed_slot_store_top #(
   parameter int SLOTS     = kss_pkg::SLOTS_DEFAULT,
   parameter int MAX_BYTES = kss_pkg::MAX_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_kind,
   input  logic [63:0] req_uid,
   input  logic [8:0]  req_length,
   input  logic [8:0]  req_offset,
   input  logic [4:0]  req_word_index,
   input  logic [63:0] req_data_in,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_data_out,
   output logic [3:0]  rsp_byte_count,
   output logic [8:0]  rsp_copied_length,
   output logic [8:0]  rsp_stored_size,
   output logic        rsp_last
);

   localparam int RSP_W = $bits(kss_pkg::rsp_type);

   kss_pkg::cmd_type cmd;
   logic             cmd_valid;
   logic             cmd_pop;
   kss_pkg::rsp_type rsp_pkt;
   logic             rsp_push;
   logic             rsp_full;
   logic [RSP_W-1:0] rsp_q_out;
   kss_pkg::rsp_type rsp_head;

   kss_front #(
      .MAX_BYTES (MAX_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_kind       (req_kind),
      .req_uid        (req_uid),
      .req_length     (req_length),
      .req_offset     (req_offset),
      .req_word_index (req_word_index),
      .req_data_in    (req_data_in),
      .cmd_valid      (cmd_valid),
      .cmd_pop        (cmd_pop),
      .cmd            (cmd)
   );

   kss_back #(
      .SLOTS     (SLOTS),
      .MAX_BYTES (MAX_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_pkt   (rsp_pkt)
   );

   // Buffer results so the back end keeps working while the consumer stalls
   kss_queue #(
      .WIDTH (RSP_W),
      .DEPTH (kss_pkg::QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_pkt),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_q_out),
      .empty     (empty)
   );

   assign rsp_head          = kss_pkg::rsp_type'(rsp_q_out);
   assign rsp_status        = rsp_head.status;
   assign rsp_data_out      = rsp_head.data_out;
   assign rsp_byte_count    = rsp_head.byte_count;
   assign rsp_copied_length = rsp_head.copied_length;
   assign rsp_stored_size   = rsp_head.stored_size;
   assign rsp_last          = rsp_head.last;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int NUM_SLOTS     = kss_pkg::SLOTS_DEFAULT;
   localparam int ENTRY_BYTES   = kss_pkg::MAX_BYTES_DEFAULT;
   localparam int ENTRY_WORDS   = ENTRY_BYTES / 8;
   localparam int KEY_POOL_SIZE = 10;
   localparam int TOTAL_ITEMS   = 120;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int LONG_HOLD     = 200;

   // Kind codes the block does not define
   localparam logic [2:0] KIND_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] KIND_RESERVED_LAST  = 3'd7;

   typedef struct {
      logic [2:0]  kind;
      logic [63:0] uid;
      logic [8:0]  length;
      logic [8:0]  offset;
      logic [4:0]  word_index;
      logic [63:0] data_in;
   } request_type;

   typedef struct {
      kss_pkg::status_type status;
      logic [63:0]         data;
      logic [3:0]          count;
      logic [8:0]          copied;
      logic [8:0]          size;
      logic                last;
   } answer_type;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [2:0]  req_kind;
   logic [63:0] req_uid;
   logic [8:0]  req_length;
   logic [8:0]  req_offset;
   logic [4:0]  req_word_index;
   logic [63:0] req_data_in;
   logic        empty;
   logic        pop;
   logic [1:0]  rsp_status;
   logic [63:0] rsp_data_out;
   logic [3:0]  rsp_byte_count;
   logic [8:0]  rsp_copied_length;
   logic [8:0]  rsp_stored_size;
   logic        rsp_last;

   // Shadow copy of the store
   bit          shadow_used    [NUM_SLOTS];
   logic [63:0] shadow_key     [NUM_SLOTS];
   int          shadow_len     [NUM_SLOTS];
   logic [63:0] shadow_word    [NUM_SLOTS][ENTRY_WORDS];
   bit          shadow_written [NUM_SLOTS][ENTRY_WORDS];
   int          shadow_target;
   bit          shadow_target_ok;

   answer_type  due_answers[$];
   logic [63:0] key_pool[KEY_POOL_SIZE];

   int errors;
   int cycles;
   int items_sent;
   int useful_items;
   int answers_checked;
   int words_streamed;
   int full_stall_cycles;
   int rx_hold_req;
   bit rx_steady;
   bit tx_steady;

   keyed_slot_store_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_kind          (req_kind),
      .req_uid           (req_uid),
      .req_length        (req_length),
      .req_offset        (req_offset),
      .req_word_index    (req_word_index),
      .req_data_in       (req_data_in),
      .empty             (empty),
      .pop               (pop),
      .rsp_status        (rsp_status),
      .rsp_data_out      (rsp_data_out),
      .rsp_byte_count    (rsp_byte_count),
      .rsp_copied_length (rsp_copied_length),
      .rsp_stored_size   (rsp_stored_size),
      .rsp_last          (rsp_last)
   );

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Count cycles, input stalls, and abort a hung run
   always @(posedge clock) begin
      cycles++;
      if (push && full) full_stall_cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached, %0d answers outstanding", $time,
                  due_answers.size());
         $display("keyed_slot_store_top regression: fail");
         $finish;
      end
   end

   // Result side: random pop with short and long holds
   initial begin
      int r;
      int rx_stall;
      rx_stall = 0;
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_req > 0) begin
            rx_stall = rx_hold_req;
            rx_hold_req = 0;
         end
         if (rx_stall > 0) begin
            pop <= 1'b0;
            rx_stall--;
         end else if (rx_steady) begin
            pop <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               pop <= 1'b1;
            end else begin
               pop <= 1'b0;
               rx_stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
         end
      end
   end

   // Compare each result transfer with the oldest expected answer
   always @(posedge clock) begin : check_answers
      answer_type want;
      if (!reset && pop && !empty) begin
         if (due_answers.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d data %h",
                     $time, rsp_status, rsp_data_out);
            errors++;
         end else begin
            want = due_answers.pop_front();
            answers_checked++;
            if (rsp_status !== want.status) begin
               $display("%0t: rsp_status expected %0d actual %0d", $time, want.status,
                        rsp_status);
               errors++;
            end
            if (rsp_data_out !== want.data) begin
               $display("%0t: rsp_data_out expected %h actual %h", $time, want.data,
                        rsp_data_out);
               errors++;
            end
            if (rsp_byte_count !== want.count) begin
               $display("%0t: rsp_byte_count expected %0d actual %0d", $time, want.count,
                        rsp_byte_count);
               errors++;
            end
            if (rsp_copied_length !== want.copied) begin
               $display("%0t: rsp_copied_length expected %0d actual %0d", $time,
                        want.copied, rsp_copied_length);
               errors++;
            end
            if (rsp_stored_size !== want.size) begin
               $display("%0t: rsp_stored_size expected %0d actual %0d", $time, want.size,
                        rsp_stored_size);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: rsp_last expected %0d actual %0d", $time, want.last,
                        rsp_last);
               errors++;
            end
         end
      end
   end

   function automatic int find_entry(logic [63:0] uid);
      for (int i = 0; i < NUM_SLOTS; i++)
         if (shadow_used[i] && shadow_key[i] == uid) return i;
      return -1;
   endfunction

   function automatic int find_vacant();
      for (int i = 0; i < NUM_SLOTS; i++)
         if (!shadow_used[i]) return i;
      return -1;
   endfunction

   function automatic void expect_answer(kss_pkg::status_type st, logic [63:0] data,
                                         int count, int copied, int size, int last);
      answer_type a;
      a.status = st;
      a.data   = data;
      a.count  = 4'(count);
      a.copied = 9'(copied);
      a.size   = 9'(size);
      a.last   = (last != 0);
      due_answers.push_back(a);
   endfunction

   // True when a get would read a data word never written since reset
   function automatic bit reads_unwritten(logic [63:0] uid, int offset, int length);
      int s;
      int copy;
      s = find_entry(uid);
      if (s < 0 || offset > shadow_len[s]) return 0;
      copy = (length < shadow_len[s] - offset) ? length : shadow_len[s] - offset;
      if (copy == 0) return 0;
      for (int w = offset / 8; w <= (offset + copy - 1) / 8; w++)
         if (!shadow_written[s][w]) return 1;
      return 0;
   endfunction

   // Apply one accepted request to the shadow store and queue its answers
   function automatic void shadow_apply(request_type r);
      int s;
      int copy;
      int done;
      int n;
      int pos;
      logic [63:0] word;
      logic [7:0]  b;
      case (r.kind)
         kss_pkg::KIND_SET: begin
            s = find_entry(r.uid);
            if (s < 0) s = find_vacant();
            if (r.length > ENTRY_BYTES || s < 0) begin
               expect_answer(kss_pkg::STATUS_NOSPACE, '0, 0, 0, 0, 1);
            end else begin
               shadow_used[s] = 1;
               shadow_key[s] = r.uid;
               shadow_len[s] = int'(r.length);
               shadow_target = s;
               shadow_target_ok = 1;
               expect_answer(kss_pkg::STATUS_OK, '0, 0, 0, 0, 1);
            end
         end
         kss_pkg::KIND_DATA: begin
            if (!shadow_target_ok || r.word_index >= ENTRY_WORDS) begin
               expect_answer(kss_pkg::STATUS_INVALID, '0, 0, 0, 0, 1);
            end else begin
               shadow_word[shadow_target][r.word_index] = r.data_in;
               shadow_written[shadow_target][r.word_index] = 1;
               expect_answer(kss_pkg::STATUS_OK, '0, 0, 0, 0, 1);
            end
         end
         kss_pkg::KIND_GET: begin
            s = find_entry(r.uid);
            if (s < 0) begin
               expect_answer(kss_pkg::STATUS_ABSENT, '0, 0, 0, 0, 1);
            end else if (r.offset > shadow_len[s]) begin
               expect_answer(kss_pkg::STATUS_INVALID, '0, 0, 0, 0, 1);
            end else begin
               copy = shadow_len[s] - r.offset;
               if (r.length < copy) copy = r.length;
               if (copy == 0) expect_answer(kss_pkg::STATUS_OK, '0, 0, 0, 0, 1);
               done = 0;
               while (done < copy) begin
                  n = (copy - done > 8) ? 8 : copy - done;
                  word = '0;
                  for (int k = 0; k < n; k++) begin
                     pos = r.offset + done + k;
                     b = 8'(shadow_word[s][pos / 8] >> ((pos % 8) * 8));
                     word[k*8 +: 8] = b;
                  end
                  done += n;
                  words_streamed++;
                  expect_answer(kss_pkg::STATUS_OK, word, n, copy, 0, int'(done >= copy));
               end
            end
         end
         kss_pkg::KIND_INFO: begin
            s = find_entry(r.uid);
            if (s < 0) expect_answer(kss_pkg::STATUS_ABSENT, '0, 0, 0, 0, 1);
            else expect_answer(kss_pkg::STATUS_OK, '0, 0, 0, shadow_len[s], 1);
         end
         kss_pkg::KIND_REMOVE: begin
            s = find_entry(r.uid);
            if (s < 0) begin
               expect_answer(kss_pkg::STATUS_ABSENT, '0, 0, 0, 0, 1);
            end else begin
               shadow_used[s] = 0;
               shadow_key[s] = '0;
               shadow_len[s] = 0;
               if (shadow_target_ok && shadow_target == s) shadow_target_ok = 0;
               expect_answer(kss_pkg::STATUS_OK, '0, 0, 0, 0, 1);
            end
         end
         default: expect_answer(kss_pkg::STATUS_INVALID, '0, 0, 0, 0, 1);
      endcase
      if (due_answers[$].status != kss_pkg::STATUS_INVALID) useful_items++;
   endfunction

   // Offer one request, hold it until the transfer, then predict
   task automatic send_request(request_type r);
      @(negedge clock);
      push           <= 1'b1;
      req_kind       <= r.kind;
      req_uid        <= r.uid;
      req_length     <= r.length;
      req_offset     <= r.offset;
      req_word_index <= r.word_index;
      req_data_in    <= r.data_in;
      do @(posedge clock); while (full);
      items_sent++;
      shadow_apply(r);
   endtask

   // Random gap on the input side, mostly short
   task automatic idle_sender();
      int r;
      int gap;
      if (tx_steady) return;
      r = $urandom_range(0, 99);
      gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      if (gap > 0) begin
         @(negedge clock);
         push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Build a request with unused fields random; keep gets off unwritten words
   task automatic issue(logic [2:0] kind, logic [63:0] uid, int length, int offset,
                        int word_index, logic [63:0] data);
      request_type r;
      r.kind       = kind;
      r.uid        = uid;
      r.length     = 9'(length);
      r.offset     = 9'(offset);
      r.word_index = 5'(word_index);
      r.data_in    = data;
      if (kind == kss_pkg::KIND_GET && reads_unwritten(uid, offset, length)) r.length = '0;
      send_request(r);
      idle_sender();
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int pick_entry_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return $urandom_range(0, 40);
      if (r < 85) return $urandom_range(41, 128);
      if (r < 95) return $urandom_range(129, ENTRY_BYTES - 1);
      return ENTRY_BYTES;
   endfunction

   // Stop offering and wait until every expected answer has arrived
   task automatic wait_drain();
      @(negedge clock);
      push <= 1'b0;
      while (due_answers.size() != 0) @(posedge clock);
   endtask

   // Set an entry, fill its words, then read it back
   task automatic store_and_read(logic [63:0] uid, int length, int reads);
      int r;
      issue(kss_pkg::KIND_SET, uid, length, $urandom_range(0, 511), $urandom_range(0, 31),
            rand64());
      for (int i = 0; i < (length + 7) / 8; i++)
         issue(kss_pkg::KIND_DATA, rand64(), $urandom_range(0, 511), $urandom_range(0, 511),
               i, rand64());
      if ($urandom_range(0, 99) < 15)
         issue(kss_pkg::KIND_DATA, rand64(), $urandom_range(0, 511), $urandom_range(0, 511),
               $urandom_range(0, ENTRY_WORDS - 1), rand64());
      for (int i = 0; i < reads; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40)
            issue(kss_pkg::KIND_GET, uid, 511, 0, $urandom_range(0, 31), rand64());
         else
            issue(kss_pkg::KIND_GET, uid, $urandom_range(0, 72),
                  $urandom_range(0, length + 4), $urandom_range(0, 31), rand64());
      end
   endtask

   // Extremes of the fields and each special case
   task automatic test_directed();
      logic [63:0] ones;
      ones = '1;
      issue(kss_pkg::KIND_GET, '0, 8, 0, 0, '0);
      issue(kss_pkg::KIND_INFO, ones, 0, 0, 0, '0);
      issue(kss_pkg::KIND_REMOVE, rand64(), 0, 0, 0, '0);
      issue(kss_pkg::KIND_DATA, rand64(), 511, 511, ENTRY_WORDS - 1, ones);
      for (logic [2:0] k = KIND_RESERVED_FIRST; k <= KIND_RESERVED_LAST; k++) begin
         issue(k, rand64(), 511, 511, 31, ones);
         if (k == KIND_RESERVED_LAST) break;
      end
      issue(kss_pkg::KIND_SET, ones, ENTRY_BYTES + 1, 0, 0, '0);
      issue(kss_pkg::KIND_SET, ones, 511, 0, 0, '0);
      issue(kss_pkg::KIND_SET, ones, 16, 0, 0, '0);
      issue(kss_pkg::KIND_DATA, '0, 0, 0, 0, ones);
      issue(kss_pkg::KIND_DATA, '0, 0, 0, 1, 64'h0123_4567_89ab_cdef);
      issue(kss_pkg::KIND_DATA, '0, 0, 0, ENTRY_WORDS - 1, '0);
      issue(kss_pkg::KIND_GET, ones, 511, 0, 0, '0);
      issue(kss_pkg::KIND_GET, ones, 5, 3, 0, '0);
      issue(kss_pkg::KIND_GET, ones, 8, 16, 0, '0);
      issue(kss_pkg::KIND_GET, ones, 8, 17, 0, '0);
      issue(kss_pkg::KIND_GET, ones, 8, 511, 0, '0);
      issue(kss_pkg::KIND_INFO, ones, 0, 0, 0, '0);
      issue(kss_pkg::KIND_SET, '0, 8, 0, 0, '0);
      issue(kss_pkg::KIND_DATA, '0, 0, 0, 0, rand64());
      issue(kss_pkg::KIND_GET, '0, 8, 0, 0, '0);
      // re-set an existing key to zero length
      issue(kss_pkg::KIND_SET, ones, 0, 0, 0, '0);
      issue(kss_pkg::KIND_INFO, ones, 0, 0, 0, '0);
      issue(kss_pkg::KIND_GET, ones, 511, 0, 0, '0);
      // removing the write target drops it
      issue(kss_pkg::KIND_REMOVE, ones, 0, 0, 0, '0);
      issue(kss_pkg::KIND_REMOVE, '0, 0, 0, 0, '0);
      issue(kss_pkg::KIND_DATA, '0, 0, 0, 0, ones);
      wait_drain();
   endtask

   // Fill every slot, overflow it, and check the target survives a failed set
   task automatic test_fill_store();
      for (int i = 0; i < NUM_SLOTS; i++)
         if (shadow_used[i]) issue(kss_pkg::KIND_REMOVE, shadow_key[i], 0, 0, 0, '0);
      for (int i = 0; i < NUM_SLOTS; i++) store_and_read(key_pool[i], 8, 0);
      issue(kss_pkg::KIND_SET, rand64(), 8, 0, 0, '0);
      issue(kss_pkg::KIND_DATA, '0, 0, 0, 0, rand64());
      issue(kss_pkg::KIND_GET, key_pool[NUM_SLOTS - 1], 8, 0, 0, '0);
      issue(kss_pkg::KIND_INFO, key_pool[0], 0, 0, 0, '0);
      issue(kss_pkg::KIND_REMOVE, key_pool[NUM_SLOTS - 1], 0, 0, 0, '0);
      issue(kss_pkg::KIND_DATA, '0, 0, 0, 0, rand64());
      issue(kss_pkg::KIND_SET, rand64(), 24, 0, 0, '0);
      wait_drain();
   endtask

   // Hold the result side off while requests keep coming, then pause to drain
   task automatic test_backpressure();
      logic [63:0] uid;
      uid = rand64();
      if (find_vacant() < 0) issue(kss_pkg::KIND_REMOVE, shadow_key[0], 0, 0, 0, '0);
      wait_drain();
      tx_steady = 1;
      rx_hold_req = LONG_HOLD;
      store_and_read(uid, ENTRY_BYTES, 0);
      issue(kss_pkg::KIND_GET, uid, ENTRY_BYTES, 0, 0, '0);
      issue(kss_pkg::KIND_GET, uid, 300, 5, 0, '0);
      issue(kss_pkg::KIND_INFO, uid, 0, 0, 0, '0);
      tx_steady = 0;
      wait_drain();
   endtask

   // Back-to-back transfers with no idling on either side
   task automatic test_streaming();
      rx_steady = 1;
      tx_steady = 1;
      store_and_read(key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)], 40, 3);
      issue(kss_pkg::KIND_INFO, key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)], 0, 0, 0,
            '0);
      wait_drain();
      rx_steady = 0;
      tx_steady = 0;
   endtask

   // Mostly well-formed set/data/get sequences, with noise mixed in
   task automatic test_random();
      int r;
      logic [63:0] uid;
      do begin
         r = $urandom_range(0, 99);
         uid = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
         if (r < 40)
            store_and_read(uid, pick_entry_length(), $urandom_range(1, 2));
         else if (r < 60)
            issue(kss_pkg::KIND_GET, uid, ($urandom_range(0, 99) < 60) ?
                  $urandom_range(0, 72) : $urandom_range(0, 511),
                  ($urandom_range(0, 99) < 70) ? $urandom_range(0, 72) :
                  $urandom_range(0, 511), $urandom_range(0, 31), rand64());
         else if (r < 68)
            issue(kss_pkg::KIND_INFO, uid, $urandom_range(0, 511), $urandom_range(0, 511),
                  $urandom_range(0, 31), rand64());
         else if (r < 78)
            issue(kss_pkg::KIND_REMOVE, uid, $urandom_range(0, 511),
                  $urandom_range(0, 511), $urandom_range(0, 31), rand64());
         else if (r < 84)
            issue(kss_pkg::KIND_DATA, rand64(), $urandom_range(0, 511),
                  $urandom_range(0, 511), $urandom_range(0, 31), rand64());
         else if (r < 88)
            issue(3'($urandom_range(KIND_RESERVED_LAST, KIND_RESERVED_FIRST)), rand64(),
                  $urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 31),
                  rand64());
         else if (r < 92)
            issue(kss_pkg::KIND_SET, uid, $urandom_range(ENTRY_BYTES + 1, 511),
                  $urandom_range(0, 511), $urandom_range(0, 31), rand64());
         else
            issue(3'($urandom_range(kss_pkg::KIND_REMOVE, kss_pkg::KIND_GET)), rand64(),
                  $urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 31),
                  rand64());
      end while (items_sent < TOTAL_ITEMS);
      wait_drain();
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      items_sent = 0;
      useful_items = 0;
      answers_checked = 0;
      words_streamed = 0;
      full_stall_cycles = 0;
      rx_hold_req = 0;
      rx_steady = 0;
      tx_steady = 0;
      shadow_target = 0;
      shadow_target_ok = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         shadow_used[i] = 0;
         shadow_key[i] = '0;
         shadow_len[i] = 0;
         for (int w = 0; w < ENTRY_WORDS; w++) begin
            shadow_word[i][w] = '0;
            shadow_written[i][w] = 0;
         end
      end
      for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = rand64();
      reset = 1'b1;
      push = 1'b0;
      req_kind = kss_pkg::KIND_SET;
      req_uid = '0;
      req_length = '0;
      req_offset = '0;
      req_word_index = '0;
      req_data_in = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_fill_store();
      test_backpressure();
      test_streaming();
      test_random();

      @(negedge clock);
      push <= 1'b0;
      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered: %0d requests, %0d answers checked, %0d get words streamed",
               items_sent, answers_checked, words_streamed);
      $display("covered: %0d useful requests, %0d cycles with the input held off, %0d errors",
               useful_items, full_stall_cycles, errors);
      if (errors == 0 && due_answers.size() == 0) begin
         $display("keyed_slot_store_top regression: pass");
      end else begin
         $display("keyed_slot_store_top regression: fail");
      end
      $finish;
   end

endmodule
